// File: hw/rtl/pse_pkg.sv
// pse_pkg: shared widths and reset constants for the prime sieve enumerator.
// No dependencies; used by prime_sieve_enumerator.
package pse_pkg;

    // Width of a number, of the limit register and of a returned prime.
    localparam int VAL_W = 13;
    // Cursor, multiple and square width: one bit over VAL_W so that limit+1 and m+p fit.
    localparam int CUR_W = VAL_W + 1;

    localparam int DEF_MAX_LIMIT = 8191;
    localparam logic [VAL_W-1:0] UPPER_LIMIT_RESET = VAL_W'(5000);

    // Largest number that can be addressed under a 13-bit limit.
    localparam int VAL_MAX = (1 << VAL_W) - 1;

endpackage

// File: hw/rtl/pse_ram.sv
// pse_ram: generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pse_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/prime_sieve_enumerator.sv
// prime_sieve_enumerator: sieve of Eratosthenes held in a one-bit-per-number bitmap RAM,
// followed by an ascending prime scan. Depends on pse_pkg and pse_ram.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+---------------------------------
//  command   | in        | start & !busy                 | i_restart
//  result    | out       | o_result_valid, 1-cycle pulse | o_prime_value, o_is_last,
//            |           |                               | o_none_left
//  config    | in        | i_cfg_valid & o_cfg_ready     | i_cfg_data (upper_limit)
//
// Operation: a restart first clears bitmap entries 0 to lim, then runs the sieve pass (one read per
// candidate p with p*p <= lim, one write per marked multiple), then a scan for the first prime
// and one for the second, one bitmap entry per cycle. A next-prime command scans from just past
// the prime it returns to the following one. The bitmap RAM has a single read port, shared by
// the sieve test and the scan.
// Reset clears control state and sets upper_limit to 5000; the bitmap has no reset and entries
// 0 to lim are rewritten by every restart. The result cannot be stalled: it is presented for one cycle.
// Configuration is always ready; a new limit is latched only at the next restart.
module prime_sieve_enumerator #(
    parameter int MAX_LIMIT = pse_pkg::DEF_MAX_LIMIT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_restart,
    // result
    output logic                     o_result_valid,
    output logic [pse_pkg::VAL_W-1:0] o_prime_value,
    output logic                     o_is_last,
    output logic                     o_none_left,
    // configuration
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [pse_pkg::VAL_W-1:0] i_cfg_data
);

    localparam int VW    = pse_pkg::VAL_W;
    localparam int CW    = pse_pkg::CUR_W;
    localparam int DEPTH = MAX_LIMIT + 1;
    localparam int AW    = $clog2(DEPTH);
    // Effective cap on the latched limit.
    localparam int CapLimit = (MAX_LIMIT < pse_pkg::VAL_MAX) ? MAX_LIMIT : pse_pkg::VAL_MAX;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,  // write 0..lim: 0 and 1 composite, rest prime
        ST_TEST  = 6'b000100,  // p*p > lim ends the sieve, else read map[p]
        ST_WAIT  = 6'b001000,  // map[p] arrives
        ST_MARK  = 6'b010000,  // write multiples of p from p*p
        ST_SCAN  = 6'b100000   // walk the bitmap for the next unmarked entry
    } t_state;

    // Control registers
    t_state          r_state, n_state;
    logic            r_ready, n_ready;       // a pending prime exists
    logic            r_first, n_first;       // scanning for the first prime after a sieve
    logic            r_rd_vld, n_rd_vld;     // scan read in flight
    logic            r_res_vld, n_res_vld;
    logic [VW-1:0]   r_upper_limit;
    // Datapath registers
    logic [VW-1:0]   r_lim, n_lim;           // limit latched at restart
    logic [CW-1:0]   r_cur, n_cur;           // clear / scan cursor
    logic [CW-1:0]   r_rd_addr, n_rd_addr;   // address of the scan read in flight
    logic [VW-1:0]   r_p, n_p;               // sieve prime candidate
    logic [CW-1:0]   r_sq, n_sq;             // r_p squared, kept incrementally
    logic [CW-1:0]   r_m, n_m;               // current multiple being marked
    logic [VW-1:0]   r_pend, n_pend;         // next prime to return
    logic [VW-1:0]   r_prime, n_prime;
    logic            r_last, n_last;
    logic            r_none, n_none;

    // RAM port signals
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [0:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [0:0]      ram_rdata;

    logic [CW-1:0]   lim_ext;
    logic [CW-1:0]   m_next;
    logic [CW-1:0]   sq_next;
    logic [VW-1:0]   cfg_capped;
    logic            accept;
    logic            scan_hit;

    assign accept     = start && !busy;
    assign lim_ext    = {1'b0, r_lim};
    assign m_next     = r_m + CW'(r_p);
    // (p+1)^2 = p^2 + 2p + 1
    assign sq_next    = r_sq + {r_p, 1'b0} + CW'(1);
    assign cfg_capped = (r_upper_limit > VW'(CapLimit)) ? VW'(CapLimit) : r_upper_limit;
    assign scan_hit   = r_rd_vld && (ram_rdata == 1'b0);

    // Bitmap RAM: one write port (clear and mark), one read port (sieve test and scan)
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_cur);
        ram_wdata = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_cur);
                ram_wdata = (r_cur < CW'(2)) ? 1'b1 : 1'b0;
            end
            ST_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_m);
                ram_wdata = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = (r_state == ST_TEST) ? AW'(r_p) : AW'(r_cur);

    pse_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_ready   = r_ready;
        n_first   = r_first;
        n_rd_vld  = 1'b0;
        n_res_vld = 1'b0;
        n_lim     = r_lim;
        n_cur     = r_cur;
        n_rd_addr = r_rd_addr;
        n_p       = r_p;
        n_sq      = r_sq;
        n_m       = r_m;
        n_pend    = r_pend;
        n_prime   = r_prime;
        n_last    = r_last;
        n_none    = r_none;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_restart) begin
                        n_lim   = cfg_capped;
                        n_cur   = '0;
                        n_ready = 1'b0;
                        n_state = ST_CLEAR;
                    end else if (r_ready) begin
                        n_first = 1'b0;
                        n_cur   = CW'(r_pend) + CW'(1);
                        n_state = ST_SCAN;
                    end else begin
                        // nothing pending: answer at once
                        n_res_vld = 1'b1;
                        n_prime   = '0;
                        n_last    = 1'b0;
                        n_none    = 1'b1;
                    end
                end
            end

            ST_CLEAR: begin
                if (r_cur == lim_ext) begin
                    n_p     = VW'(2);
                    n_sq    = CW'(4);
                    n_state = ST_TEST;
                end else begin
                    n_cur = r_cur + CW'(1);
                end
            end

            ST_TEST: begin
                if (r_sq > lim_ext) begin
                    n_first = 1'b1;
                    n_cur   = CW'(2);
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_WAIT;
                end
            end

            ST_WAIT: begin
                if (ram_rdata == 1'b1) begin
                    n_p     = r_p + VW'(1);
                    n_sq    = sq_next;
                    n_state = ST_TEST;
                end else begin
                    n_m     = r_sq;
                    n_state = ST_MARK;
                end
            end

            ST_MARK: begin
                if (m_next > lim_ext) begin
                    n_p     = r_p + VW'(1);
                    n_sq    = sq_next;
                    n_state = ST_TEST;
                end else begin
                    n_m = m_next;
                end
            end

            ST_SCAN: begin
                if (scan_hit) begin
                    if (r_first) begin
                        // first prime found; go on to find the one after it
                        n_pend  = VW'(r_rd_addr);
                        n_cur   = r_rd_addr + CW'(1);
                        n_first = 1'b0;
                    end else begin
                        n_res_vld = 1'b1;
                        n_prime   = r_pend;
                        n_last    = 1'b0;
                        n_none    = 1'b0;
                        n_pend    = VW'(r_rd_addr);
                        n_ready   = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end else if (r_cur <= lim_ext) begin
                    n_rd_addr = r_cur;
                    n_rd_vld  = 1'b1;
                    n_cur     = r_cur + CW'(1);
                end else begin
                    // walked past the limit with no unmarked entry
                    n_res_vld = 1'b1;
                    n_ready   = 1'b0;
                    n_state   = ST_IDLE;
                    if (r_first) begin
                        n_prime = '0;
                        n_last  = 1'b0;
                        n_none  = 1'b1;
                    end else begin
                        n_prime = r_pend;
                        n_last  = 1'b1;
                        n_none  = 1'b0;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ready       <= 1'b0;
            r_first       <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_res_vld     <= 1'b0;
            r_upper_limit <= pse_pkg::UPPER_LIMIT_RESET;
        end else begin
            r_state   <= n_state;
            r_ready   <= n_ready;
            r_first   <= n_first;
            r_rd_vld  <= n_rd_vld;
            r_res_vld <= n_res_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_upper_limit <= i_cfg_data;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_lim     <= n_lim;
        r_cur     <= n_cur;
        r_rd_addr <= n_rd_addr;
        r_p       <= n_p;
        r_sq      <= n_sq;
        r_m       <= n_m;
        r_pend    <= n_pend;
        r_prime   <= n_prime;
        r_last    <= n_last;
        r_none    <= n_none;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_res_vld;
    assign o_prime_value  = r_prime;
    assign o_is_last      = r_last;
    assign o_none_left    = r_none;

    // Checks
    // every result is presented while idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_none_left) |-> (o_prime_value == '0 && !o_is_last))
        else $error("none_left result carries a prime");

    a_prime_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_none_left) |-> (o_prime_value >= VW'(2)))
        else $error("returned prime below two");

    a_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_restart) |=> (busy && !o_result_valid))
        else $error("restart did not start the sieve");

endmodule
